FILE: rtl/core/jcsf_pkg.sv
// shared types and constants of the joint command safety filter
`default_nettype none

package jcsf_pkg;

   // frame shape and field widths
   localparam int JOINTS      = 6;
   localparam int SIDES       = 2;
   localparam int JOINT_W     = 3;
   localparam int SIDE_W      = 1;
   localparam int ANGLE_W     = 16;
   localparam int FORCE_W     = 16;
   localparam int OUT_W       = 10;
   localparam int FLIM_W      = 15;
   localparam int HITS_W      = 4;
   localparam int ALU_W       = 17;
   localparam int OUT_MAX     = 2**OUT_W - 1;

   // band rule covers these joints
   localparam int RULE1_FIRST = 3;
   localparam int RULE1_LAST  = 5;

   // rules_hit bit positions
   localparam int HIT_BAND    = 0;
   localparam int HIT_FORCE   = 1;
   localparam int HIT_CLAMP   = 2;
   localparam int HIT_MEAN    = 3;

   // register file
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 15;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BAND_LIMIT    = 3'd0,
      CSR_FORCE_LIMIT   = 3'd1,
      CSR_ANGLE_MAX     = 3'd2,
      CSR_JUMP_LIMIT    = 3'd3,
      CSR_DEFAULT_ANGLE = 3'd4
   } csr_index_type;

   localparam logic [OUT_W-1:0]  BAND_RESET    = 10'd200;
   localparam logic [FLIM_W-1:0] FORCE_RESET   = 15'd3000;
   localparam logic [OUT_W-1:0]  AMAX_RESET    = 10'd1000;
   localparam logic [OUT_W-1:0]  JUMP_RESET    = 10'd200;
   localparam logic [OUT_W-1:0]  DEFAULT_RESET = 10'd1000;

   // shared compare unit
   typedef enum logic {
      ALU_GT   = 1'b0,
      ALU_JUMP = 1'b1
   } alu_op_type;

   typedef struct packed {
      alu_op_type              op;
      logic signed [ALU_W-1:0] a;
      logic signed [ALU_W-1:0] b;
      logic [OUT_W-1:0]        lim;
   } alu_req_type;

endpackage

`default_nettype wire

FILE: rtl/core/jcsf_alu.sv
// shared subtract and compare unit of the safety filter sequencer
`default_nettype none

module jcsf_alu (
   input  jcsf_pkg::alu_req_type req,
   output logic                  flag
);

   logic signed [jcsf_pkg::ALU_W:0] diff;
   logic [jcsf_pkg::ALU_W:0]        absd;

   assign diff = {req.a[jcsf_pkg::ALU_W-1], req.a} - {req.b[jcsf_pkg::ALU_W-1], req.b};
   assign absd = diff[jcsf_pkg::ALU_W] ? (~diff + 1'b1) : diff;

   always_comb begin
      case (req.op)
         jcsf_pkg::ALU_GT: begin
            flag = !diff[jcsf_pkg::ALU_W] && (diff != '0);
         end
         jcsf_pkg::ALU_JUMP: begin
            flag = absd > {{(jcsf_pkg::ALU_W + 1 - jcsf_pkg::OUT_W){1'b0}}, req.lim};
         end
         default: begin
            flag = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/core/joint_command_safety_filter_unit.sv
// Joint command safety filter: buffers joint samples, filters each closed frame.
// A sample for joints 0..4 is taken while idle; the block is ready again next cycle.
// The closing sample runs setup, the band rule (two or more history frames), then per
// joint start, R read/accumulate steps, rules, a last step with a full window, mul and
// div when averaged, and emit, which waits out output stalls. R = history reads
// (window-1 when full, 1 with history, 0 without). Synchronous reset
// clears sequencer, registers to defaults, history counts and force flags.
`default_nettype none

module joint_command_safety_filter_unit #(
   parameter int WINDOW_FRAMES = 5
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [jcsf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [jcsf_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [jcsf_pkg::SIDE_W-1:0]          req_hand_side,
   input  logic [jcsf_pkg::JOINT_W-1:0]         req_joint_index,
   input  logic signed [jcsf_pkg::ANGLE_W-1:0]  req_raw_angle,
   input  logic signed [jcsf_pkg::FORCE_W-1:0]  req_joint_force,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [jcsf_pkg::SIDE_W-1:0]          rsp_out_side,
   output logic [jcsf_pkg::JOINT_W-1:0]         rsp_out_joint,
   output logic [jcsf_pkg::OUT_W-1:0]           rsp_safe_angle,
   output logic [jcsf_pkg::HITS_W-1:0]          rsp_rules_hit,
   output logic                                 rsp_frame_last
);

   localparam int HIST      = WINDOW_FRAMES - 1;
   localparam int PTR_W     = $clog2(HIST);
   localparam int CNT_W     = $clog2(HIST + 1);
   localparam int SUM_W     = $clog2(WINDOW_FRAMES * jcsf_pkg::OUT_MAX + 1);
   localparam int NUM_W     = SUM_W + 2;
   localparam int DIVISOR   = 2 * WINDOW_FRAMES;
   localparam int DIV_L     = $clog2(DIVISOR);
   localparam int SHIFT     = NUM_W + DIV_L;
   localparam int MULT      = (2**SHIFT + DIVISOR - 1) / DIVISOR;
   localparam int MULT_W    = NUM_W + 2;
   localparam int PROD_W    = NUM_W + MULT_W;
   localparam int ADDR_W    = jcsf_pkg::SIDE_W + PTR_W + jcsf_pkg::JOINT_W;
   localparam int MEM_DEPTH = 2**ADDR_W;
   localparam int OUT_W     = jcsf_pkg::OUT_W;
   localparam int ALU_W     = jcsf_pkg::ALU_W;
   localparam int JOINT_W   = jcsf_pkg::JOINT_W;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SETUP,
      ST_LOW_CUR,
      ST_LOW_NEW,
      ST_LOW_OLD,
      ST_J_START,
      ST_J_RD,
      ST_J_ACC,
      ST_J_RULES,
      ST_J_LAST,
      ST_J_MUL,
      ST_J_DIV,
      ST_J_EMIT
   } state_type;

   function automatic logic [PTR_W-1:0] slot_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(HIST - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [PTR_W-1:0] slot_dec(input logic [PTR_W-1:0] p);
      return (p == '0) ? PTR_W'(HIST - 1) : p - 1'b1;
   endfunction

   function automatic logic signed [ALU_W-1:0] zext(input logic [OUT_W-1:0] v);
      return {{(ALU_W - OUT_W){1'b0}}, v};
   endfunction

   state_type state_ff, state_in;

   logic [OUT_W-1:0]                band_ff, band_in;
   logic [jcsf_pkg::FLIM_W-1:0]     flim_ff, flim_in;
   logic [OUT_W-1:0]                amax_ff, amax_in;
   logic [OUT_W-1:0]                jlim_ff, jlim_in;
   logic [OUT_W-1:0]                dflt_ff, dflt_in;

   logic [CNT_W-1:0]                hcnt_ff [jcsf_pkg::SIDES];
   logic [CNT_W-1:0]                hcnt_in [jcsf_pkg::SIDES];
   logic [PTR_W-1:0]                hptr_ff [jcsf_pkg::SIDES];
   logic [PTR_W-1:0]                hptr_in [jcsf_pkg::SIDES];

   logic signed [jcsf_pkg::ANGLE_W-1:0] fa_ff [jcsf_pkg::JOINTS];
   logic signed [jcsf_pkg::ANGLE_W-1:0] fa_in [jcsf_pkg::JOINTS];
   logic                            fo_ff [jcsf_pkg::JOINTS];
   logic                            fo_in [jcsf_pkg::JOINTS];

   logic [jcsf_pkg::SIDE_W-1:0]     side_ff, side_in;
   logic [CNT_W-1:0]                cnt_ff, cnt_in;
   logic                            low_ok_ff, low_ok_in;
   logic [1:0]                      low_j_ff, low_j_in;
   logic [JOINT_W-1:0]              jn_ff, jn_in;
   logic [PTR_W-1:0]                slot_ff, slot_in;
   logic [CNT_W-1:0]                left_ff, left_in;
   logic [OUT_W-1:0]                prev_ff, prev_in;
   logic                            prev_vld_ff, prev_vld_in;
   logic                            jump_ff, jump_in;
   logic [SUM_W-1:0]                sum_ff, sum_in;
   logic [OUT_W-1:0]                ang_ff, ang_in;
   logic [jcsf_pkg::HITS_W-1:0]     hits_ff, hits_in;
   logic [PROD_W-1:0]               prod_ff, prod_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [jcsf_pkg::SIDE_W-1:0]     rsp_side_ff, rsp_side_in;
   logic [JOINT_W-1:0]              rsp_joint_ff, rsp_joint_in;
   logic [OUT_W-1:0]                rsp_angle_ff, rsp_angle_in;
   logic [jcsf_pkg::HITS_W-1:0]     rsp_hits_ff, rsp_hits_in;
   logic                            rsp_last_ff, rsp_last_in;

   logic [OUT_W-1:0]                hist_mem_ff [MEM_DEPTH];
   logic [OUT_W-1:0]                rd_data_ff;
   logic [ADDR_W-1:0]               rd_addr;
   logic [ADDR_W-1:0]               wr_addr;
   logic                            mem_we;

   jcsf_pkg::alu_req_type           alu_req;
   logic                            alu_flag;

   logic                            full;
   logic [PTR_W-1:0]                ptr_cur;
   logic [PTR_W-1:0]                newest_slot;
   logic [PTR_W-1:0]                second_slot;
   logic [JOINT_W-1:0]              low_joint;
   logic [JOINT_W-1:0]              fa_idx;
   logic signed [jcsf_pkg::ANGLE_W-1:0] fa_rd;
   logic signed [ALU_W-1:0]         pre;
   logic [NUM_W-1:0]                num;
   logic                            rsp_load;

   jcsf_alu u_alu (
      .req  (alu_req),
      .flag (alu_flag)
   );

   assign full        = (cnt_ff == CNT_W'(HIST));
   assign ptr_cur     = hptr_ff[side_ff];
   assign newest_slot = slot_dec(ptr_cur);
   assign second_slot = slot_dec(newest_slot);
   assign low_joint   = JOINT_W'(jcsf_pkg::RULE1_FIRST) + JOINT_W'(low_j_ff);
   assign fa_idx      = (state_ff == ST_LOW_CUR) ? low_joint : jn_ff;
   assign fa_rd       = fa_ff[fa_idx];
   assign num         = NUM_W'({sum_ff, 1'b0}) + NUM_W'(WINDOW_FRAMES);
   assign wr_addr     = {side_ff, ptr_cur, jn_ff};

   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_side   = rsp_side_ff;
   assign rsp_out_joint  = rsp_joint_ff;
   assign rsp_safe_angle = rsp_angle_ff;
   assign rsp_rules_hit  = rsp_hits_ff;
   assign rsp_frame_last = rsp_last_ff;

   always_comb begin
      state_in    = state_ff;
      band_in     = band_ff;
      flim_in     = flim_ff;
      amax_in     = amax_ff;
      jlim_in     = jlim_ff;
      dflt_in     = dflt_ff;
      hcnt_in     = hcnt_ff;
      hptr_in     = hptr_ff;
      fa_in       = fa_ff;
      fo_in       = fo_ff;
      side_in     = side_ff;
      cnt_in      = cnt_ff;
      low_ok_in   = low_ok_ff;
      low_j_in    = low_j_ff;
      jn_in       = jn_ff;
      slot_in     = slot_ff;
      left_in     = left_ff;
      prev_in     = prev_ff;
      prev_vld_in = prev_vld_ff;
      jump_in     = jump_ff;
      sum_in      = sum_ff;
      ang_in      = ang_ff;
      hits_in     = hits_ff;
      prod_in     = prod_ff;
      req_ready   = 1'b0;
      rd_addr     = {side_ff, newest_slot, jn_ff};
      mem_we      = 1'b0;
      rsp_load    = 1'b0;
      pre         = '0;
      alu_req.op  = jcsf_pkg::ALU_GT;
      alu_req.a   = '0;
      alu_req.b   = '0;
      alu_req.lim = jlim_ff;

      if (csr_valid) begin
         unique case (csr_index)
            jcsf_pkg::CSR_BAND_LIMIT:    band_in = csr_wdata[OUT_W-1:0];
            jcsf_pkg::CSR_FORCE_LIMIT:   flim_in = csr_wdata[jcsf_pkg::FLIM_W-1:0];
            jcsf_pkg::CSR_ANGLE_MAX:     amax_in = csr_wdata[OUT_W-1:0];
            jcsf_pkg::CSR_JUMP_LIMIT:    jlim_in = csr_wdata[OUT_W-1:0];
            jcsf_pkg::CSR_DEFAULT_ANGLE: dflt_in = csr_wdata[OUT_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            // force over limit, signed compare
            alu_req.a = {req_joint_force[jcsf_pkg::FORCE_W-1], req_joint_force};
            alu_req.b = {{(ALU_W - jcsf_pkg::FLIM_W){1'b0}}, flim_ff};
            if (req_valid && (req_joint_index < JOINT_W'(jcsf_pkg::JOINTS))) begin
               fa_in[req_joint_index] = req_raw_angle;
               fo_in[req_joint_index] = alu_flag;
               if (req_joint_index == JOINT_W'(jcsf_pkg::JOINTS - 1)) begin
                  side_in  = req_hand_side;
                  cnt_in   = hcnt_ff[req_hand_side];
                  state_in = ST_SETUP;
               end
            end
         end
         ST_SETUP: begin
            jn_in     = '0;
            low_j_in  = '0;
            low_ok_in = (cnt_ff >= CNT_W'(2));
            state_in  = (cnt_ff >= CNT_W'(2)) ? ST_LOW_CUR : ST_J_START;
         end
         ST_LOW_CUR: begin
            alu_req.a = {fa_rd[jcsf_pkg::ANGLE_W-1], fa_rd};
            alu_req.b = zext(band_ff);
            if (fa_rd[jcsf_pkg::ANGLE_W-1] || alu_flag) begin
               low_ok_in = 1'b0;
            end
            rd_addr  = {side_ff, newest_slot, low_joint};
            state_in = ST_LOW_NEW;
         end
         ST_LOW_NEW: begin
            alu_req.a = zext(rd_data_ff);
            alu_req.b = zext(band_ff);
            if (alu_flag) begin
               low_ok_in = 1'b0;
            end
            rd_addr  = {side_ff, second_slot, low_joint};
            state_in = ST_LOW_OLD;
         end
         ST_LOW_OLD: begin
            alu_req.a = zext(rd_data_ff);
            alu_req.b = zext(band_ff);
            if (alu_flag) begin
               low_ok_in = 1'b0;
            end
            if (low_j_ff == 2'(jcsf_pkg::RULE1_LAST - jcsf_pkg::RULE1_FIRST)) begin
               state_in = ST_J_START;
            end else begin
               low_j_in = low_j_ff + 1'b1;
               state_in = ST_LOW_CUR;
            end
         end
         ST_J_START: begin
            sum_in      = '0;
            prev_vld_in = 1'b0;
            jump_in     = 1'b0;
            // full window walks oldest to newest, otherwise only the newest frame if there is one
            if (full) begin
               slot_in = ptr_cur;
               left_in = CNT_W'(HIST);
            end else begin
               slot_in = newest_slot;
               left_in = (cnt_ff != '0) ? CNT_W'(1) : '0;
            end
            state_in = (cnt_ff != '0) ? ST_J_RD : ST_J_RULES;
         end
         ST_J_RD: begin
            rd_addr  = {side_ff, slot_ff, jn_ff};
            state_in = ST_J_ACC;
         end
         ST_J_ACC: begin
            alu_req.op = jcsf_pkg::ALU_JUMP;
            alu_req.a  = zext(prev_ff);
            alu_req.b  = zext(rd_data_ff);
            if (prev_vld_ff && alu_flag) begin
               jump_in = 1'b1;
            end
            sum_in      = sum_ff + SUM_W'(rd_data_ff);
            prev_in     = rd_data_ff;
            prev_vld_in = 1'b1;
            slot_in     = slot_inc(slot_ff);
            left_in     = left_ff - 1'b1;
            state_in    = (left_ff == CNT_W'(1)) ? ST_J_RULES : ST_J_RD;
         end
         ST_J_RULES: begin
            hits_in = '0;
            pre     = {fa_rd[jcsf_pkg::ANGLE_W-1], fa_rd};
            if (low_ok_ff && (jn_ff >= JOINT_W'(jcsf_pkg::RULE1_FIRST))
                && (jn_ff <= JOINT_W'(jcsf_pkg::RULE1_LAST))) begin
               pre                         = zext(band_ff);
               hits_in[jcsf_pkg::HIT_BAND] = 1'b1;
            end
            if (fo_ff[jn_ff]) begin
               pre                          = (cnt_ff != '0) ? zext(prev_ff) : zext(dflt_ff);
               hits_in[jcsf_pkg::HIT_FORCE] = 1'b1;
            end
            alu_req.a = pre;
            alu_req.b = zext(amax_ff);
            if (pre[ALU_W-1]) begin
               ang_in                       = '0;
               hits_in[jcsf_pkg::HIT_CLAMP] = 1'b1;
            end else if (alu_flag) begin
               ang_in                       = amax_ff;
               hits_in[jcsf_pkg::HIT_CLAMP] = 1'b1;
            end else begin
               ang_in = pre[OUT_W-1:0];
            end
            state_in = full ? ST_J_LAST : ST_J_EMIT;
         end
         ST_J_LAST: begin
            // newest history frame against the current angle
            alu_req.op = jcsf_pkg::ALU_JUMP;
            alu_req.a  = zext(prev_ff);
            alu_req.b  = zext(ang_ff);
            sum_in     = sum_ff + SUM_W'(ang_ff);
            if (jump_ff || alu_flag) begin
               hits_in[jcsf_pkg::HIT_MEAN] = 1'b1;
               state_in                    = ST_J_MUL;
            end else begin
               state_in = ST_J_EMIT;
            end
         end
         ST_J_MUL: begin
            // rounded mean via reciprocal multiply
            prod_in  = PROD_W'(num) * PROD_W'(MULT);
            state_in = ST_J_DIV;
         end
         ST_J_DIV: begin
            ang_in   = prod_ff[SHIFT +: OUT_W];
            state_in = ST_J_EMIT;
         end
         ST_J_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               mem_we   = 1'b1;
               if (jn_ff == JOINT_W'(jcsf_pkg::JOINTS - 1)) begin
                  hcnt_in[side_ff] = full ? cnt_ff : cnt_ff + 1'b1;
                  hptr_in[side_ff] = slot_inc(ptr_cur);
                  state_in         = ST_IDLE;
               end else begin
                  jn_in    = jn_ff + 1'b1;
                  state_in = ST_J_START;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);
      rsp_side_in  = rsp_load ? side_ff : rsp_side_ff;
      rsp_joint_in = rsp_load ? jn_ff : rsp_joint_ff;
      rsp_angle_in = rsp_load ? ang_ff : rsp_angle_ff;
      rsp_hits_in  = rsp_load ? hits_ff : rsp_hits_ff;
      rsp_last_in  = rsp_load ? (jn_ff == JOINT_W'(jcsf_pkg::JOINTS - 1)) : rsp_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         band_ff      <= jcsf_pkg::BAND_RESET;
         flim_ff      <= jcsf_pkg::FORCE_RESET;
         amax_ff      <= jcsf_pkg::AMAX_RESET;
         jlim_ff      <= jcsf_pkg::JUMP_RESET;
         dflt_ff      <= jcsf_pkg::DEFAULT_RESET;
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s < jcsf_pkg::SIDES; s++) begin
            hcnt_ff[s] <= '0;
            hptr_ff[s] <= '0;
         end
         for (int j = 0; j < jcsf_pkg::JOINTS; j++) begin
            fo_ff[j] <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         band_ff      <= band_in;
         flim_ff      <= flim_in;
         amax_ff      <= amax_in;
         jlim_ff      <= jlim_in;
         dflt_ff      <= dflt_in;
         rsp_valid_ff <= rsp_valid_in;
         hcnt_ff      <= hcnt_in;
         hptr_ff      <= hptr_in;
         fo_ff        <= fo_in;
      end
      fa_ff        <= fa_in;
      side_ff      <= side_in;
      cnt_ff       <= cnt_in;
      low_ok_ff    <= low_ok_in;
      low_j_ff     <= low_j_in;
      jn_ff        <= jn_in;
      slot_ff      <= slot_in;
      left_ff      <= left_in;
      prev_ff      <= prev_in;
      prev_vld_ff  <= prev_vld_in;
      jump_ff      <= jump_in;
      sum_ff       <= sum_in;
      ang_ff       <= ang_in;
      hits_ff      <= hits_in;
      prod_ff      <= prod_in;
      rsp_side_ff  <= rsp_side_in;
      rsp_joint_ff <= rsp_joint_in;
      rsp_angle_ff <= rsp_angle_in;
      rsp_hits_ff  <= rsp_hits_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // output history, circular per side, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         hist_mem_ff[wr_addr] <= ang_ff;
      end
      rd_data_ff <= hist_mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

FILE: rtl/core/jcsf_checker.sv
// port-level checks of the safety filter and their binding to the top level
`default_nettype none

module jcsf_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic [jcsf_pkg::JOINT_W-1:0]        req_joint_index,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [jcsf_pkg::JOINT_W-1:0]        rsp_out_joint,
   input logic [jcsf_pkg::OUT_W-1:0]          rsp_safe_angle,
   input logic [jcsf_pkg::HITS_W-1:0]         rsp_rules_hit,
   input logic                                rsp_frame_last
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_safe_angle)
                                 && $stable(rsp_out_joint))
      else $error("result beat changed while stalled");

   // the frame end flag marks exactly the last joint
   a_last_joint: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_frame_last
                     == (rsp_out_joint == jcsf_pkg::JOINT_W'(jcsf_pkg::JOINTS - 1))))
      else $error("frame_last does not match the last joint");

   // the band rule only touches its joint range
   a_band_joints: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rules_hit[jcsf_pkg::HIT_BAND]
      |-> (rsp_out_joint >= jcsf_pkg::JOINT_W'(jcsf_pkg::RULE1_FIRST))
          && (rsp_out_joint <= jcsf_pkg::JOINT_W'(jcsf_pkg::RULE1_LAST)))
      else $error("band rule reported outside its joints");

   // a closing sample starts frame work and stops input
   a_busy_after_close: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready
      && (req_joint_index == jcsf_pkg::JOINT_W'(jcsf_pkg::JOINTS - 1))
      |=> !req_ready)
      else $error("input accepted right after a frame closed");

endmodule

bind joint_command_safety_filter_unit jcsf_checker u_jcsf_checker (.*);

`default_nettype wire

FILE: test/tb.sv
// testbench for the joint command safety filter: random framed samples checked against a predictor
`timescale 1ns / 1ps

module tb;

   localparam int SIDE_W       = jcsf_pkg::SIDE_W;
   localparam int JOINT_W      = jcsf_pkg::JOINT_W;
   localparam int ANGLE_W      = jcsf_pkg::ANGLE_W;
   localparam int FORCE_W      = jcsf_pkg::FORCE_W;
   localparam int OUT_W        = jcsf_pkg::OUT_W;
   localparam int HITS_W       = jcsf_pkg::HITS_W;
   localparam int FLIM_W       = jcsf_pkg::FLIM_W;
   localparam int CSR_IDX_W    = jcsf_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W   = jcsf_pkg::CSR_DATA_W;
   localparam int JOINTS       = jcsf_pkg::JOINTS;
   localparam int SIDES        = jcsf_pkg::SIDES;
   localparam int OUT_MAX      = jcsf_pkg::OUT_MAX;
   localparam int RULE1_FIRST  = jcsf_pkg::RULE1_FIRST;
   localparam int RULE1_LAST   = jcsf_pkg::RULE1_LAST;
   localparam int HIT_BAND     = jcsf_pkg::HIT_BAND;
   localparam int HIT_FORCE    = jcsf_pkg::HIT_FORCE;
   localparam int HIT_CLAMP    = jcsf_pkg::HIT_CLAMP;
   localparam int HIT_MEAN     = jcsf_pkg::HIT_MEAN;

   localparam int WINDOW       = 5;
   localparam int HIST_FRAMES  = WINDOW - 1;
   localparam int DRAIN_CYCLES = 20;
   localparam int TAIL_CYCLES  = 200;
   localparam int MAX_PRINTED  = 50;

   typedef struct packed {
      logic [SIDE_W-1:0]         side;
      logic [JOINT_W-1:0]        joint;
      logic signed [ANGLE_W-1:0] angle;
      logic signed [FORCE_W-1:0] load;
   } joint_sample_type;

   typedef struct packed {
      logic [SIDE_W-1:0]  side;
      logic [JOINT_W-1:0] joint;
      logic [OUT_W-1:0]   angle;
      logic [HITS_W-1:0]  hits;
      logic               last;
   } safe_joint_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_IDX_W-1:0]      csr_index = '0;
   logic [CSR_DATA_W-1:0]     csr_wdata = '0;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [SIDE_W-1:0]         req_hand_side = '0;
   logic [JOINT_W-1:0]        req_joint_index = '0;
   logic signed [ANGLE_W-1:0] req_raw_angle = '0;
   logic signed [FORCE_W-1:0] req_joint_force = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [SIDE_W-1:0]         rsp_out_side;
   logic [JOINT_W-1:0]        rsp_out_joint;
   logic [OUT_W-1:0]          rsp_safe_angle;
   logic [HITS_W-1:0]         rsp_rules_hit;
   logic                      rsp_frame_last;

   // register copies
   logic [OUT_W-1:0]  cfg_band    = jcsf_pkg::BAND_RESET;
   logic [FLIM_W-1:0] cfg_force   = jcsf_pkg::FORCE_RESET;
   logic [OUT_W-1:0]  cfg_amax    = jcsf_pkg::AMAX_RESET;
   logic [OUT_W-1:0]  cfg_jump    = jcsf_pkg::JUMP_RESET;
   logic [OUT_W-1:0]  cfg_default = jcsf_pkg::DEFAULT_RESET;

   // frame buffer and per-side output window
   logic signed [ANGLE_W-1:0] held_angle [JOINTS];
   bit                        held_heavy [JOINTS];
   logic [OUT_W-1:0]          hist [SIDES][HIST_FRAMES][JOINTS];
   int                        hist_len [SIDES];

   joint_sample_type sample_q[$];
   safe_joint_type   safe_q[$];

   bit req_beat;
   bit low_side [SIDES];
   int issued_count, accepted_count, frames_closed, results_checked, mismatches;
   int rule_hits [HITS_W];
   int burst_left, gap_left, ready_left;
   logic [11:0] ready_pat = '1;

   joint_command_safety_filter_unit #(
      .WINDOW_FRAMES(WINDOW)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_hand_side  (req_hand_side),
      .req_joint_index(req_joint_index),
      .req_raw_angle  (req_raw_angle),
      .req_joint_force(req_joint_force),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_side   (rsp_out_side),
      .rsp_out_joint  (rsp_out_joint),
      .rsp_safe_angle (rsp_safe_angle),
      .rsp_rules_hit  (rsp_rules_hit),
      .rsp_frame_last (rsp_frame_last)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      if (mismatches < MAX_PRINTED) begin
         $display("tb: mismatch at %0t: %s", $realtime, msg);
      end
      mismatches++;
   endtask

   // buffer one sample; on the closing joint filter the frame and queue six results
   task automatic take_joint_sample(input logic [SIDE_W-1:0] side,
                                    input logic [JOINT_W-1:0] joint,
                                    input logic signed [ANGLE_W-1:0] angle,
                                    input logic signed [FORCE_W-1:0] load);
      int cnt, a, b, d, sum, j, k;
      int ang [JOINTS];
      logic [HITS_W-1:0] hits [JOINTS];
      bit in_band, jumped;
      safe_joint_type r;
      if (int'(joint) >= JOINTS || int'(side) >= SIDES) return;
      held_angle[joint] = angle;
      held_heavy[joint] = int'(load) > int'(cfg_force);
      if (int'(joint) != JOINTS - 1) return;
      frames_closed++;
      cnt = (hist_len[side] > HIST_FRAMES) ? HIST_FRAMES : hist_len[side];
      for (j = 0; j < JOINTS; j++) begin
         ang[j]  = int'(held_angle[j]);
         hits[j] = '0;
      end
      // low band on the last joints of two previous outputs and this frame
      if (cnt >= 2) begin
         in_band = 1'b1;
         for (j = RULE1_FIRST; j <= RULE1_LAST; j++) begin
            if (hist[side][cnt-2][j] > cfg_band || hist[side][cnt-1][j] > cfg_band ||
                ang[j] < 0 || ang[j] > int'(cfg_band)) begin
               in_band = 1'b0;
            end
         end
         if (in_band) begin
            for (j = RULE1_FIRST; j <= RULE1_LAST; j++) begin
               ang[j] = int'(cfg_band);
               hits[j][HIT_BAND] = 1'b1;
            end
         end
      end
      for (j = 0; j < JOINTS; j++) begin
         if (held_heavy[j]) begin
            ang[j] = (cnt > 0) ? int'(hist[side][cnt-1][j]) : int'(cfg_default);
            hits[j][HIT_FORCE] = 1'b1;
         end
      end
      for (j = 0; j < JOINTS; j++) begin
         if (ang[j] < 0) begin
            ang[j] = 0;
            hits[j][HIT_CLAMP] = 1'b1;
         end else if (ang[j] > int'(cfg_amax)) begin
            ang[j] = int'(cfg_amax);
            hits[j][HIT_CLAMP] = 1'b1;
         end
      end
      // window mean on a jump, only with a full history
      if (cnt == HIST_FRAMES) begin
         for (j = 0; j < JOINTS; j++) begin
            jumped = 1'b0;
            sum = ang[j];
            for (k = 0; k < HIST_FRAMES; k++) begin
               a = int'(hist[side][k][j]);
               b = (k + 1 < HIST_FRAMES) ? int'(hist[side][k+1][j]) : ang[j];
               d = (a > b) ? a - b : b - a;
               if (d > int'(cfg_jump)) jumped = 1'b1;
               sum += a;
            end
            if (jumped) begin
               ang[j] = (2 * sum + WINDOW) / (2 * WINDOW);
               hits[j][HIT_MEAN] = 1'b1;
            end
         end
         for (k = 0; k + 1 < HIST_FRAMES; k++) begin
            for (j = 0; j < JOINTS; j++) hist[side][k][j] = hist[side][k+1][j];
         end
         cnt = HIST_FRAMES - 1;
      end
      for (j = 0; j < JOINTS; j++) begin
         hist[side][cnt][j] = OUT_W'(ang[j]);
         r.side  = side;
         r.joint = JOINT_W'(j);
         r.angle = OUT_W'(ang[j]);
         r.hits  = hits[j];
         r.last  = (j == JOINTS - 1);
         safe_q.insert(safe_q.size(), r);
         for (k = 0; k < HITS_W; k++) begin
            if (hits[j][k]) rule_hits[k]++;
         end
      end
      hist_len[side] = cnt + 1;
   endtask

   // result check, then prediction of the sample taken at this edge
   always @(posedge clock) begin : watch_beats
      safe_joint_type want;
      req_beat = !reset && req_valid && req_ready;
      if (!reset && rsp_valid && rsp_ready) begin
         results_checked++;
         if (safe_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result joint %0d angle %0d",
                                      rsp_out_joint, rsp_safe_angle));
         end else begin
            want = safe_q.pop_front();
            if (rsp_out_side !== want.side)
               report_mismatch($sformatf("joint %0d side got %0d want %0d",
                                         want.joint, rsp_out_side, want.side));
            if (rsp_out_joint !== want.joint)
               report_mismatch($sformatf("joint got %0d want %0d", rsp_out_joint, want.joint));
            if (rsp_safe_angle !== want.angle)
               report_mismatch($sformatf("joint %0d angle got %0d want %0d",
                                         want.joint, rsp_safe_angle, want.angle));
            if (rsp_rules_hit !== want.hits)
               report_mismatch($sformatf("joint %0d rules got %b want %b",
                                         want.joint, rsp_rules_hit, want.hits));
            if (rsp_frame_last !== want.last)
               report_mismatch($sformatf("joint %0d last got %0d want %0d",
                                         want.joint, rsp_frame_last, want.last));
         end
      end
      if (req_beat) begin
         accepted_count++;
         take_joint_sample(req_hand_side, req_joint_index, req_raw_angle, req_joint_force);
      end
   end

   // sample driver: bursts of beats with random gaps
   always @(negedge clock) begin : drive_samples
      joint_sample_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_beat) begin
         // hold until the beat is taken
      end else if (gap_left > 0) begin
         gap_left--;
         req_valid <= 1'b0;
      end else if (sample_q.size() > 0) begin
         nxt = sample_q.pop_front();
         req_hand_side   <= nxt.side;
         req_joint_index <= nxt.joint;
         req_raw_angle   <= nxt.angle;
         req_joint_force <= nxt.load;
         req_valid       <= 1'b1;
         if (burst_left > 0) burst_left--;
         if (burst_left == 0) begin
            gap_left   = $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 10);
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   // result stall pattern, refreshed now and then, sometimes all ready
   always @(negedge clock) begin
      if (ready_left == 0) begin
         ready_left = $urandom_range(20, 80);
         ready_pat  = ($urandom_range(0, 3) == 0) ? '1 : (12'($urandom) | 12'd1);
      end
      ready_left--;
      ready_pat = {ready_pat[0], ready_pat[11:1]};
      rsp_ready <= ready_pat[0];
   end

   task automatic push_sample(input int side, input int joint, input int angle, input int load);
      joint_sample_type s;
      s.side  = SIDE_W'(side);
      s.joint = JOINT_W'(joint);
      s.angle = ANGLE_W'(angle);
      s.load  = FORCE_W'(load);
      sample_q.insert(sample_q.size(), s);
      issued_count++;
   endtask

   task automatic write_reg(input jcsf_pkg::csr_index_type idx, input int value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      do @(posedge clock); while (!csr_ready);
      case (idx)
         jcsf_pkg::CSR_BAND_LIMIT:    cfg_band    = OUT_W'(value);
         jcsf_pkg::CSR_FORCE_LIMIT:   cfg_force   = FLIM_W'(value);
         jcsf_pkg::CSR_ANGLE_MAX:     cfg_amax    = OUT_W'(value);
         jcsf_pkg::CSR_JUMP_LIMIT:    cfg_jump    = OUT_W'(value);
         jcsf_pkg::CSR_DEFAULT_ANGLE: cfg_default = OUT_W'(value);
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_limits(input int band, input int flim, input int amax, input int jump,
                             input int dflt);
      write_reg(jcsf_pkg::CSR_BAND_LIMIT, band);
      write_reg(jcsf_pkg::CSR_FORCE_LIMIT, flim);
      write_reg(jcsf_pkg::CSR_ANGLE_MAX, amax);
      write_reg(jcsf_pkg::CSR_JUMP_LIMIT, jump);
      write_reg(jcsf_pkg::CSR_DEFAULT_ANGLE, dflt);
   endtask

   // the sender holds off here until every result is back
   task automatic wait_for_drain();
      @(negedge clock);
      while (!(accepted_count == issued_count && safe_q.size() == 0)) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // mostly whole frames with random content; some partial, mixed-side, ignored and broken
   task automatic queue_random_items(input int target);
      int added, kind, base, side, j, k, n, ang, frc;
      bit partial;
      added = 0;
      while (added < target) begin
         kind = $urandom_range(0, 99);
         if (kind < 85) begin
            side = $urandom_range(0, 1);
            partial = (kind >= 70);
            if ($urandom_range(0, 9) < 3) low_side[side] = !low_side[side];
            base = $urandom_range(0, OUT_MAX);
            for (j = 0; j < JOINTS; j++) begin
               if (!partial || j == JOINTS - 1 || $urandom_range(0, 1) == 1) begin
                  k = $urandom_range(0, 99);
                  if (low_side[side] && j >= RULE1_FIRST) ang = $urandom_range(0, cfg_band);
                  else if (k < 78) ang = base + int'($urandom_range(0, 120)) - 60;
                  else if (k < 88) ang = $urandom_range(0, OUT_MAX);
                  else if (k < 94) ang = -int'($urandom_range(1, 32768));
                  else ang = $urandom;
                  k = $urandom_range(0, 99);
                  if (k < 12 && cfg_force < FLIM_W'(32767))
                     frc = $urandom_range(int'(cfg_force) + 1, 32767);
                  else if (k < 22) frc = $urandom;
                  else frc = $urandom_range(0, cfg_force);
                  push_sample((partial && j != JOINTS - 1) ? $urandom_range(0, 1) : side,
                              j, ang, frc);
                  added++;
               end
            end
         end else if (kind < 95) begin
            push_sample($urandom_range(0, 1), $urandom_range(JOINTS, 7), $urandom, $urandom);
         end else begin
            // samples with no closing joint
            n = $urandom_range(1, 3);
            for (k = 0; k < n; k++) begin
               push_sample($urandom_range(0, 1), $urandom_range(0, JOINTS - 2),
                           $urandom_range(0, OUT_MAX), $urandom);
               added++;
            end
         end
      end
   endtask

   initial begin : timeout
      #5_000_000;
      $display("tb: FAIL");
      $finish;
   end

   initial begin
      burst_left = 8;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes, force boundary, no-history hold, band rule
      push_sample(0, 0, 32767, -32768);
      push_sample(0, 1, -32768, 32767);
      push_sample(0, 2, 0, 3001);
      push_sample(0, 3, 100, 3000);
      push_sample(0, 4, 150, 0);
      push_sample(0, 5, 50, -1);
      push_sample(0, 0, 600, 0);
      push_sample(0, 1, 620, 5000);
      push_sample(0, 2, 640, 0);
      push_sample(0, 3, 10, 0);
      push_sample(0, 4, 20, 0);
      push_sample(0, 5, 30, 0);
      push_sample(0, 0, 610, 0);
      push_sample(0, 1, 630, 0);
      push_sample(0, 2, 1023, 0);
      push_sample(0, 3, 0, 0);
      push_sample(0, 4, 200, 0);
      push_sample(0, 5, 199, 0);
      // out of range joints are dropped
      push_sample(1, 6, 16'h5555, 16'haaaa);
      push_sample(0, 7, -1, 12345);
      // mixed sides and stale joints, then a jump that fills the window
      push_sample(1, 0, 500, 0);
      push_sample(0, 5, 900, 0);
      push_sample(0, 5, 40, 0);
      wait_for_drain();

      set_limits(1000, 0, OUT_MAX, 0, 0);
      @(posedge clock);
      queue_random_items(25);
      wait_for_drain();

      set_limits(0, 32767, OUT_MAX, OUT_MAX, OUT_MAX);
      @(posedge clock);
      queue_random_items(25);
      wait_for_drain();

      // lowered clamp under a window of high angles
      set_limits(200, 3000, 300, 100, 500);
      @(posedge clock);
      queue_random_items(25);
      wait_for_drain();

      set_limits($urandom_range(0, 1000), $urandom_range(0, 32767), $urandom_range(0, OUT_MAX),
                 $urandom_range(0, OUT_MAX), $urandom_range(0, OUT_MAX));
      @(posedge clock);
      queue_random_items(25);
      wait_for_drain();
      repeat (TAIL_CYCLES) @(negedge clock);

      if (safe_q.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", safe_q.size()));
      $display("tb: %0d samples over 5 register settings, %0d frames, %0d joint results checked",
               accepted_count, frames_closed, results_checked);
      $display("tb: rule hits band %0d force %0d clamp %0d mean %0d, %0d mismatches",
               rule_hits[HIT_BAND], rule_hits[HIT_FORCE], rule_hits[HIT_CLAMP],
               rule_hits[HIT_MEAN], mismatches);
      if (mismatches == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/jcsf_pkg.sv
rtl/core/jcsf_alu.sv
rtl/core/joint_command_safety_filter_unit.sv
rtl/core/jcsf_checker.sv
test/tb.sv
